@@ rtl/ssfp_pkg.sv @@
// Shared constants and types for the sensor serial frame parser.
package ssfp_pkg;

  localparam logic [7:0] HEAD_BYTE    = 8'hAA;
  localparam logic [7:0] TAIL_BYTE    = 8'hAB;
  localparam logic [7:0] TYPE_MEASURE = 8'hC0;
  localparam logic [7:0] TYPE_REPLY   = 8'hC5;
  localparam logic [7:0] CMD_RESET    = 8'h02;

  localparam int unsigned PAYLOAD_LEN = 6;
  localparam int unsigned IDX_W       = $clog2(PAYLOAD_LEN);

  // Byte positions within a frame
  localparam logic [3:0] POS_HEAD     = 4'd0;
  localparam logic [3:0] POS_TYPE     = 4'd1;
  localparam logic [3:0] POS_PAY_FRST = 4'd2;
  localparam logic [3:0] POS_PAY_LAST = 4'd7;
  localparam logic [3:0] POS_CSUM     = 4'd8;
  localparam logic [3:0] POS_TAIL     = 4'd9;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_REPLY   = 1'b1;

  typedef struct packed {
    logic        frame_kind;
    logic [15:0] pm25_tenths;
    logic [15:0] pm10_tenths;
    logic [7:0]  reply_command;
    logic [7:0]  reply_second;
    logic [7:0]  reply_third;
    logic [7:0]  reply_fourth;
    logic [15:0] device_id;
  } result_t;

endpackage

@@ rtl/ssfp_if.sv @@
// Valid/ready channel interfaces for the received byte and the parsed frame.
interface ssfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ssfp_out_if;
  logic        valid;
  logic        ready;
  logic        frame_kind;
  logic [15:0] pm25_tenths;
  logic [15:0] pm10_tenths;
  logic [7:0]  reply_command;
  logic [7:0]  reply_second;
  logic [7:0]  reply_third;
  logic [7:0]  reply_fourth;
  logic [15:0] device_id;

  modport source (output valid, output frame_kind, output pm25_tenths, output pm10_tenths,
                  output reply_command, output reply_second, output reply_third,
                  output reply_fourth, output device_id, input ready);
  modport sink   (input valid, input frame_kind, input pm25_tenths, input pm10_tenths,
                  input reply_command, input reply_second, input reply_third,
                  input reply_fourth, input device_id, output ready);
endinterface

@@ rtl/ssfp_frame_fsm.sv @@
// Frame recognizer: byte position, checksum, payload store and result build.
module ssfp_frame_fsm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic             byte_en,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output ssfp_pkg::result_t res_data
);
  import ssfp_pkg::*;

  logic [7:0]       exp_cmd_r;
  logic [3:0]       pos_r, pos_nxt;
  logic             type_r, type_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       store_r [PAYLOAD_LEN];
  logic             store_we;
  logic [IDX_W-1:0] store_idx;
  logic             is_pay;

  assign is_pay    = (pos_r >= POS_PAY_FRST) && (pos_r <= POS_PAY_LAST);
  assign store_idx = IDX_W'(pos_r - POS_PAY_FRST);

  always_comb begin
    pos_nxt   = pos_r;
    type_nxt  = type_r;
    sum_nxt   = sum_r;
    store_we  = 1'b0;
    res_valid = 1'b0;
    if (byte_en) begin
      // default: mismatch drops the byte and restarts the head hunt
      pos_nxt  = POS_HEAD;
      type_nxt = KIND_MEASURE;
      sum_nxt  = 8'h00;
      priority if (is_pay) begin
        if (!(pos_r == POS_PAY_FRST && type_r == KIND_REPLY && rx_byte != exp_cmd_r)) begin
          pos_nxt  = pos_r + 4'd1;
          type_nxt = type_r;
          sum_nxt  = sum_r + rx_byte;
          store_we = 1'b1;
        end
      end else if (pos_r == POS_TYPE) begin
        if (rx_byte == TYPE_MEASURE) begin
          pos_nxt = POS_PAY_FRST;
        end else if (rx_byte == TYPE_REPLY) begin
          pos_nxt  = POS_PAY_FRST;
          type_nxt = KIND_REPLY;
        end
      end else if (pos_r == POS_CSUM) begin
        if (rx_byte == sum_r) begin
          pos_nxt  = POS_TAIL;
          type_nxt = type_r;
          sum_nxt  = sum_r;
        end
      end else if (pos_r == POS_TAIL) begin
        res_valid = (rx_byte == TAIL_BYTE);
      end else begin
        // head hunt, also taken from unreachable positions
        if (rx_byte == HEAD_BYTE) begin
          pos_nxt = POS_TYPE;
        end
      end
    end
  end

  always_comb begin
    res_data               = '0;
    res_data.frame_kind    = type_r;
    if (type_r == KIND_REPLY) begin
      res_data.reply_command = store_r[0];
      res_data.reply_second  = store_r[1];
      res_data.reply_third   = store_r[2];
      res_data.reply_fourth  = store_r[3];
    end else begin
      res_data.pm25_tenths = {store_r[1], store_r[0]};
      res_data.pm10_tenths = {store_r[3], store_r[2]};
    end
    res_data.device_id = {store_r[4], store_r[5]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cmd_r <= CMD_RESET;
      pos_r     <= POS_HEAD;
      type_r    <= KIND_MEASURE;
      sum_r     <= 8'h00;
    end else begin
      if (cfg_we) begin
        exp_cmd_r <= cfg_wdata;
      end
      pos_r  <= pos_nxt;
      type_r <= type_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[store_idx] <= rx_byte;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n) pos_r <= POS_TAIL)
    else $error("frame position out of range");
  a_res_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (pos_r == POS_TAIL && byte_en))
    else $error("result outside tail byte");

endmodule

@@ rtl/ssfp_out_stage.sv @@
// Output register with a skid entry, decoupling the parser from the result sink.
module ssfp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ssfp_pkg::result_t push_data,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_ready,
  output ssfp_pkg::result_t out_data
);
  import ssfp_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;

  assign pop      = out_valid_r && out_ready;
  assign can_take = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_data_nxt  = push_data;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_data_nxt  = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed into full output stage");
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready && push))
    else $error("skid filled without a stalled output");

endmodule

@@ rtl/sensor_serial_frame_parser_unit.sv @@
// Top level of the sensor serial frame parser.
// Takes one received byte per transaction and returns one transaction per complete,
// valid 10-byte frame (head 0xAA, type 0xC0 or 0xC5, six payload bytes, sum checksum,
// tail 0xAB). A byte can be taken every cycle that in_ch.ready is high: the frame state
// advances in the cycle the byte is accepted, and a result is registered into the
// output register, or the one-entry skid buffer while the output stalls. Both let input
// flow while a result waits; in_ch.ready drops only while both hold undelivered results.
// Measurement values are raw in tenths of ug/m3. cfg_we writes the expected reply
// command (reset 0x02) and must only be used while the block is idle.
module sensor_serial_frame_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  ssfp_in_if.sink    in_ch,
  ssfp_out_if.source out_ch
);
  import ssfp_pkg::*;

  logic    in_accept;
  logic    res_valid;
  result_t res_data;
  result_t out_data;
  logic    can_take;

  assign in_ch.ready = can_take;
  assign in_accept   = in_ch.valid && can_take;

  ssfp_frame_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_en   (in_accept),
    .rx_byte   (in_ch.rx_byte),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  ssfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .can_take  (can_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.frame_kind    = out_data.frame_kind;
  assign out_ch.pm25_tenths   = out_data.pm25_tenths;
  assign out_ch.pm10_tenths   = out_data.pm10_tenths;
  assign out_ch.reply_command = out_data.reply_command;
  assign out_ch.reply_second  = out_data.reply_second;
  assign out_ch.reply_third   = out_data.reply_third;
  assign out_ch.reply_fourth  = out_data.reply_fourth;
  assign out_ch.device_id     = out_data.device_id;

endmodule

@@ tb/sensor_serial_frame_parser_unit_tb.sv @@
// Self-checking testbench for the sensor serial frame parser: byte stream in, parsed frames out.
module sensor_serial_frame_parser_unit_tb;
  import ssfp_pkg::*;

  typedef enum {
    FAULT_NONE,
    FAULT_CSUM,
    FAULT_TAIL,
    FAULT_TAIL_HEAD,
    FAULT_TRUNC,
    FAULT_NO_HEAD
  } frame_fault_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  ssfp_in_if  in_ch ();
  ssfp_out_if out_ch ();

  sensor_serial_frame_parser_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Frame tracker state, mirrors the parser
  logic [3:0] frame_pos;
  logic       frame_is_reply;
  logic [7:0] payload_sum;
  logic [7:0] payload_bytes [PAYLOAD_LEN];
  logic [7:0] expected_cmd;

  result_t     pending_frames [$];
  int unsigned mismatch_count  = 0;
  int unsigned frame_bytes_sent = 0;
  bit          sender_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  int unsigned stall_left  = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic void hunt_restart();
    frame_pos      = POS_HEAD;
    frame_is_reply = 1'b0;
    payload_sum    = 8'h00;
  endfunction

  // Advances the frame tracker by one byte; returns 1 when a frame completes.
  function automatic bit track_byte(input logic [7:0] b, output result_t r);
    logic [3:0] p;
    bit         done;
    p    = (frame_pos > POS_TAIL) ? POS_HEAD : frame_pos;
    done = 1'b0;
    r    = '0;
    case (p)
      POS_HEAD: begin
        hunt_restart();
        if (b == HEAD_BYTE) frame_pos = POS_TYPE;
      end
      POS_TYPE: begin
        if (b == TYPE_MEASURE) begin
          frame_is_reply = 1'b0;
          frame_pos      = POS_PAY_FRST;
        end else if (b == TYPE_REPLY) begin
          frame_is_reply = 1'b1;
          frame_pos      = POS_PAY_FRST;
        end else begin
          hunt_restart();
        end
      end
      POS_CSUM: begin
        if (b == payload_sum) frame_pos = POS_TAIL;
        else hunt_restart();
      end
      POS_TAIL: begin
        if (b == TAIL_BYTE) begin
          done         = 1'b1;
          r.frame_kind = frame_is_reply ? KIND_REPLY : KIND_MEASURE;
          if (frame_is_reply) begin
            r.reply_command = payload_bytes[0];
            r.reply_second  = payload_bytes[1];
            r.reply_third   = payload_bytes[2];
            r.reply_fourth  = payload_bytes[3];
          end else begin
            r.pm25_tenths = {payload_bytes[1], payload_bytes[0]};
            r.pm10_tenths = {payload_bytes[3], payload_bytes[2]};
          end
          r.device_id = {payload_bytes[4], payload_bytes[5]};
        end
        hunt_restart();
      end
      default: begin
        // payload bytes; a reply's first byte must match the configured command
        if (p == POS_PAY_FRST && frame_is_reply && b != expected_cmd) begin
          hunt_restart();
        end else begin
          payload_bytes[p - POS_PAY_FRST] = b;
          payload_sum = payload_sum + b;
          frame_pos   = p + 4'd1;
        end
      end
    endcase
    return done;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("kind=%0d pm25=%h pm10=%h reply=%h %h %h %h id=%h",
                     r.frame_kind, r.pm25_tenths, r.pm10_tenths, r.reply_command,
                     r.reply_second, r.reply_third, r.reply_fourth, r.device_id);
  endfunction

  // Sink side: random stalls, now and then a longer one to back up the output
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (sink_stalls && $urandom_range(0, 99) < 6) begin
      out_ch.ready <= 1'b0;
      stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 24) : 0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_frames
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      got.frame_kind    = out_ch.frame_kind;
      got.pm25_tenths   = out_ch.pm25_tenths;
      got.pm10_tenths   = out_ch.pm10_tenths;
      got.reply_command = out_ch.reply_command;
      got.reply_second  = out_ch.reply_second;
      got.reply_third   = out_ch.reply_third;
      got.reply_fourth  = out_ch.reply_fourth;
      got.device_id     = out_ch.device_id;
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected frame at %0t: %s", $time, fmt_result(got));
      end else begin
        want = pending_frames.pop_front();
        if (got.frame_kind !== want.frame_kind || got.pm25_tenths !== want.pm25_tenths ||
            got.pm10_tenths !== want.pm10_tenths ||
            got.reply_command !== want.reply_command ||
            got.reply_second !== want.reply_second || got.reply_third !== want.reply_third ||
            got.reply_fourth !== want.reply_fourth || got.device_id !== want.device_id) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch at %0t: expected %s", $time, fmt_result(want));
            $display("                 actual   %s", fmt_result(got));
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    result_t r;
    while (sender_gaps && $urandom_range(0, 99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (track_byte(b, r)) pending_frames.push_back(r);
  endtask

  // Payload byte 0 sits in pay[7:0], byte 5 in pay[47:40].
  task automatic send_frame(input logic [7:0] kind_byte, input logic [47:0] pay,
                            input frame_fault_t fault);
    logic [7:0] frame [10];
    logic [7:0] csum;
    int         first;
    int         last;
    csum = 8'h00;
    for (int i = 0; i < 6; i++) csum += pay[8*i +: 8];
    if (fault == FAULT_CSUM) csum ^= 8'($urandom_range(1, 255));
    frame[0] = HEAD_BYTE;
    frame[1] = kind_byte;
    for (int i = 0; i < 6; i++) frame[2 + i] = pay[8*i +: 8];
    frame[8] = csum;
    frame[9] = TAIL_BYTE;
    if (fault == FAULT_TAIL_HEAD) begin
      frame[9] = HEAD_BYTE;
    end else if (fault == FAULT_TAIL) begin
      do frame[9] = 8'($urandom); while (frame[9] == TAIL_BYTE);
    end
    first = (fault == FAULT_NO_HEAD) ? 1 : 0;
    last  = (fault == FAULT_TRUNC) ? $urandom_range(1, 8) : 9;
    for (int k = first; k <= last; k++) send_byte(frame[k]);
    frame_bytes_sent += last - first + 1;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_expected_cmd(input logic [7:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    expected_cmd  = v;
  endtask

  function automatic logic [7:0] rand_pay_byte();
    int unsigned pick;
    logic [7:0]  b;
    pick = $urandom_range(0, 9);
    b    = 8'($urandom);
    if (pick == 0) b = 8'h00;
    else if (pick == 1) b = 8'hFF;
    return b;
  endfunction

  function automatic logic [47:0] rand_payload();
    logic [47:0] pay;
    for (int i = 0; i < 6; i++) pay[8*i +: 8] = rand_pay_byte();
    return pay;
  endfunction

  task automatic test_measure_frames();
    send_frame(TYPE_MEASURE, 48'h0, FAULT_NONE);
    send_frame(TYPE_MEASURE, {48{1'b1}}, FAULT_NONE);
    // head and tail values inside the payload must not disturb framing
    send_frame(TYPE_MEASURE, 48'hAB_AA_AB_AA_01_80, FAULT_NONE);
  endtask

  task automatic test_reply_frames();
    send_frame(TYPE_REPLY, {40'hFF_FF_00_FF_00, expected_cmd}, FAULT_NONE);
    send_frame(TYPE_REPLY, {40'h01_23_45_67_89, expected_cmd}, FAULT_NONE);
    // command byte differs from the expected one: dropped
    send_frame(TYPE_REPLY, {40'h11_22_33_44_55, expected_cmd ^ 8'h01}, FAULT_NONE);
  endtask

  task automatic test_framing_errors();
    // doubled head: the second one is a bad type and is not taken as a new head
    send_byte(HEAD_BYTE);
    send_frame(TYPE_MEASURE, 48'h06_05_04_03_02_01, FAULT_NONE);
    send_frame(8'hC1, 48'h0, FAULT_NONE);
    send_frame(TYPE_MEASURE, 48'h10_20_30_40_50_60, FAULT_CSUM);
    send_frame(TYPE_MEASURE, 48'h10_20_30_40_50_60, FAULT_TAIL_HEAD);
    send_frame(TYPE_MEASURE, 48'h10_20_30_40_50_60, FAULT_NO_HEAD);
    send_frame(TYPE_REPLY, {40'h0, expected_cmd}, FAULT_TAIL);
    send_frame(TYPE_MEASURE, 48'hFE_DC_BA_98_76_54, FAULT_NONE);
  endtask

  task automatic test_config_sweep();
    logic [7:0] vals [4];
    vals = '{8'h00, 8'hFF, 8'h00, 8'h5A};
    vals[2] = 8'($urandom);
    foreach (vals[i]) begin
      write_expected_cmd(vals[i]);
      send_frame(TYPE_REPLY, {rand_payload()} & 48'hFFFF_FFFF_FF00 | vals[i], FAULT_NONE);
      send_frame(TYPE_REPLY, {40'hA5_5A_A5_5A_A5, vals[i] + 8'h01}, FAULT_NONE);
      send_frame(TYPE_MEASURE, rand_payload(), FAULT_NONE);
    end
  endtask

  task automatic test_random_traffic(input int unsigned byte_goal);
    int unsigned start;
    int unsigned next_cfg;
    int unsigned pick;
    logic [7:0]  kind_byte;
    logic [47:0] pay;
    start    = frame_bytes_sent;
    next_cfg = 150;
    while (frame_bytes_sent - start < byte_goal) begin
      if (frame_bytes_sent - start >= next_cfg) begin
        next_cfg += 150;
        pick = $urandom_range(0, 3);
        write_expected_cmd(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom));
      end
      pick      = $urandom_range(0, 99);
      kind_byte = $urandom_range(0, 1) ? TYPE_REPLY : TYPE_MEASURE;
      pay       = rand_payload();
      if (kind_byte == TYPE_REPLY && $urandom_range(0, 9) != 0) pay[7:0] = expected_cmd;
      if (pick < 66) begin
        send_frame(kind_byte, pay, FAULT_NONE);
      end else if (pick < 71) begin
        send_frame(kind_byte, pay, FAULT_CSUM);
      end else if (pick < 74) begin
        send_frame(kind_byte, pay, FAULT_TAIL);
      end else if (pick < 77) begin
        send_frame(kind_byte, pay, FAULT_TAIL_HEAD);
      end else if (pick < 83) begin
        send_frame(kind_byte, pay, FAULT_TRUNC);
      end else if (pick < 86) begin
        send_frame(kind_byte, pay, FAULT_NO_HEAD);
      end else if (pick < 90) begin
        do kind_byte = 8'($urandom);
        while (kind_byte == TYPE_MEASURE || kind_byte == TYPE_REPLY);
        send_frame(kind_byte, pay, FAULT_NONE);
      end else begin
        // line noise, heavy on head bytes
        repeat ($urandom_range(1, 6))
          send_byte($urandom_range(0, 9) < 3 ? HEAD_BYTE : 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 8'h00;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    hunt_restart();
    expected_cmd  = CMD_RESET;
    foreach (payload_bytes[i]) payload_bytes[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_measure_frames();
    test_reply_frames();
    test_framing_errors();
    test_config_sweep();
    test_random_traffic(350);
    // a further run at full rate on both sides
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_random_traffic(230);
    wait_idle();

    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
